// ===== design/word_frequency_counter_defines.svh =====
// assertion macros for the word frequency counter
`ifndef WORD_FREQUENCY_COUNTER_DEFINES_SVH
`define WORD_FREQUENCY_COUNTER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define WFC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property that must hold also during reset
`define WFC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/wfc_pkg.sv =====
// shared types and constants of the word frequency counter
`default_nettype none
package wfc_pkg;
   localparam int WordLen    = 16;
   localparam int TableDepth = 256;
   localparam int PosW       = $clog2(WordLen);
   localparam int IdxW       = $clog2(TableDepth);
   localparam int LenW       = 5;
   localparam int CntW       = 24;
   localparam int UsedW      = 9;
   localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

   localparam logic [1:0] OpText  = 2'd0;
   localparam logic [1:0] OpFlush = 2'd1;
   localparam logic [1:0] OpRead  = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] text_byte;
      logic [7:0] entry_index;
      logic [3:0] char_position;
   } req_type;

   typedef struct packed {
      logic [7:0]       entry_byte;
      logic [LenW-1:0]  entry_length;
      logic [CntW-1:0]  entry_count;
      logic [UsedW-1:0] entries_used;
      logic [CntW-1:0]  tokens_total;
      logic             table_full;
   } rsp_type;
endpackage
`default_nettype wire

// ===== design/word_frequency_counter.sv =====
// top level of the word frequency counter: sequencer, table memories and totals
// a text byte that closes no word does not stall input; a closing word stalls input while
//   ST_LOOK and ST_CMP walk the entries (one comparator on the shared memory read port)
// read item: result registered through ST_RDA and ST_RDB, held in the output register
//   until taken; the next word is accepted meanwhile, a second read waits for the first
// reset: synchronous active high; clears counters and state, table memories not cleared
`default_nettype none
`include "word_frequency_counter_defines.svh"
module word_frequency_counter (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire wfc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output wfc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [4:0]       csr_data
);
   import wfc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOOK  = 6'b000010,  // issue read of entry length and word; append or drop when scan is done
      ST_CMP   = 6'b000100,  // compare read data with pending word
      ST_HIT   = 6'b001000,  // count read back, write incremented
      ST_RDA   = 6'b010000,  // read item: memory read issued
      ST_RDB   = 6'b100000   // read item: memory data valid, load output register
   } state_type;

   state_type              state_ff, state_in;
   logic [4:0]             min_len_ff;
   logic [7:0]             pend_ff [WordLen];
   logic [LenW-1:0]        plen_ff, plen_in;
   logic [LenW-1:0]        wlen_ff;           // length of the word being searched
   logic [IdxW-1:0]        scan_ff, scan_in;
   logic [UsedW-1:0]       used_ff, used_in;
   logic [CntW-1:0]        tokens_ff, tokens_in;
   logic                   full_ff, full_in;
   req_type                hold_ff;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // table storage: whole word per row, one read port, one write port each
   logic [8*WordLen-1:0]   word_mem [TableDepth];
   logic [LenW-1:0]        len_mem  [TableDepth];
   logic [CntW-1:0]        cnt_mem  [TableDepth];
   logic [8*WordLen-1:0]   word_rd_ff;
   logic [LenW-1:0]        len_rd_ff;
   logic [CntW-1:0]        cnt_rd_ff;
   logic [IdxW-1:0]        rd_addr;
   logic                   word_we, cnt_we;
   logic [IdxW-1:0]        wr_addr;
   logic [CntW-1:0]        cnt_wdata;
   logic [8*WordLen-1:0]   pend_flat;
   logic                   match;

   // byte classification
   logic       is_upper, is_lower, is_letter, start_close;
   logic [7:0] low_byte;
   logic [4:0] need_len;
   logic       req_fire, rsp_fire;

   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_upper  = req_data.text_byte >= 8'h41 && req_data.text_byte <= 8'h5a;
   assign is_lower  = req_data.text_byte >= 8'h61 && req_data.text_byte <= 8'h7a;
   assign is_letter = is_upper || is_lower;
   assign low_byte  = is_upper ? req_data.text_byte + 8'd32 : req_data.text_byte;
   assign need_len  = (min_len_ff == 5'd0) ? 5'd1 : min_len_ff;

   always_comb begin
      for (int i = 0; i < WordLen; i++) begin
         pend_flat[8*i +: 8] = pend_ff[i];
      end
   end

   // masked compare of stored word against pending word over its length
   always_comb begin
      match = (len_rd_ff == wlen_ff);
      for (int i = 0; i < WordLen; i++) begin
         if (LenW'(i) < wlen_ff && word_rd_ff[8*i +: 8] != pend_ff[i]) begin
            match = 1'b0;
         end
      end
   end

   // decide whether an accepted byte or flush closes a word worth searching
   logic [LenW-1:0] close_len;
   always_comb begin
      start_close = 1'b0;
      close_len   = plen_ff;
      if (req_data.op == OpText) begin
         if (is_letter) begin
            close_len   = plen_ff + LenW'(1);
            start_close = (close_len >= LenW'(WordLen));
         end else begin
            start_close = 1'b1;
         end
      end else if (req_data.op == OpFlush) begin
         start_close = 1'b1;
      end
      if (close_len == '0 || close_len < need_len) begin
         start_close = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      plen_in      = plen_ff;
      scan_in      = scan_ff;
      used_in      = used_ff;
      tokens_in    = tokens_ff;
      full_in      = full_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr      = scan_ff;
      word_we      = 1'b0;
      cnt_we       = 1'b0;
      wr_addr      = scan_ff;
      cnt_wdata    = cnt_rd_ff;
      if (rsp_fire) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               scan_in = '0;
               if (req_data.op == OpRead) begin
                  state_in = ST_RDA;
               end else if (req_data.op == OpText || req_data.op == OpFlush) begin
                  plen_in = (req_data.op == OpText && is_letter && !start_close
                             && close_len < LenW'(WordLen)) ? close_len : '0;
                  if (start_close) begin
                     state_in = ST_LOOK;
                  end
               end
            end
         end
         ST_LOOK: begin
            if (UsedW'(scan_ff) >= used_ff) begin
               // not found: append or drop
               if (used_ff >= UsedW'(TableDepth)) begin
                  full_in = 1'b1;
               end else begin
                  word_we   = 1'b1;
                  cnt_we    = 1'b1;
                  wr_addr   = used_ff[IdxW-1:0];
                  cnt_wdata = CntW'(1);
                  used_in   = used_ff + UsedW'(1);
                  if (tokens_ff != CountMax) tokens_in = tokens_ff + CntW'(1);
               end
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (match) begin
               state_in = ST_HIT;
            end else begin
               scan_in  = scan_ff + IdxW'(1);
               rd_addr  = scan_ff + IdxW'(1);
               state_in = ST_LOOK;
               if (scan_ff == IdxW'(TableDepth - 1)) begin
                  // table walked completely; force the not-found path
                  scan_in = scan_ff;
                  if (used_ff >= UsedW'(TableDepth)) begin
                     full_in  = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_HIT: begin
            cnt_we = 1'b1;
            if (cnt_rd_ff != CountMax) cnt_wdata = cnt_rd_ff + CntW'(1);
            if (tokens_ff != CountMax) tokens_in = tokens_ff + CntW'(1);
            state_in = ST_IDLE;
         end
         ST_RDA: begin
            rd_addr  = hold_ff.entry_index[IdxW-1:0];
            state_in = ST_RDB;
         end
         ST_RDB: begin
            // keep the entry on the read port while an older result waits
            rd_addr = hold_ff.entry_index[IdxW-1:0];
            if (!rsp_valid_ff || rsp_fire) begin
               rsp_in.entries_used = used_ff;
               rsp_in.tokens_total = tokens_ff;
               rsp_in.table_full   = full_ff;
               rsp_in.entry_byte   = '0;
               rsp_in.entry_length = '0;
               rsp_in.entry_count  = '0;
               if (UsedW'(hold_ff.entry_index) < used_ff) begin
                  rsp_in.entry_length = len_rd_ff;
                  rsp_in.entry_count  = cnt_rd_ff;
                  if (LenW'(hold_ff.char_position) < len_rd_ff) begin
                     rsp_in.entry_byte = word_rd_ff[8*hold_ff.char_position +: 8];
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memories: registered read, read address from the sequencer
   always_ff @(posedge clock) begin
      word_rd_ff <= word_mem[rd_addr];
      len_rd_ff  <= len_mem[rd_addr];
      cnt_rd_ff  <= cnt_mem[rd_addr];
      if (word_we) begin
         word_mem[wr_addr] <= pend_flat;
         len_mem[wr_addr]  <= wlen_ff;
      end
      if (cnt_we) cnt_mem[wr_addr] <= cnt_wdata;
   end

   // pending word bytes and held request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_ff <= req_data;
         if (req_data.op == OpText && is_letter && plen_ff < LenW'(WordLen)) begin
            pend_ff[plen_ff[PosW-1:0]] <= low_byte;
         end
         if (start_close) wlen_ff <= close_len;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_len_ff   <= 5'd3;
         plen_ff      <= '0;
         scan_ff      <= '0;
         used_ff      <= '0;
         tokens_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         scan_ff      <= scan_in;
         used_ff      <= used_in;
         tokens_ff    <= tokens_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) min_len_ff <= csr_data;
      end
   end

   `WFC_ASSERT(a_used_bound, used_ff <= UsedW'(TableDepth), "entry count past table depth")
   `WFC_ASSERT(a_full_sticky, $past(full_ff) |-> full_ff, "table full flag dropped")
   `WFC_ASSERT(a_stall_busy, (state_ff != ST_IDLE) |-> req_stall, "word accepted while busy")
   `WFC_ASSERT(a_plen_bound, plen_ff < LenW'(WordLen), "pending length out of range")
   `WFC_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)), "stalled result changed")
endmodule
`default_nettype wire
